### rtl/pso_pkg.sv
`default_nettype none
package pso_pkg;

  localparam int COORD_BITS = 24;
  localparam int WIDTH_BITS = 16;
  localparam int UNIT_BITS  = 16;
  localparam int VEC_BITS   = COORD_BITS + 1;
  localparam int MAG_BITS   = 31;
  localparam int SQ_BITS    = 64;
  localparam int LEN_BITS   = 32;
  localparam int ROOT_STEPS = SQ_BITS / 2;
  localparam int NUM_BITS   = MAG_BITS + UNIT_BITS;
  localparam int PROD_BITS  = WIDTH_BITS + UNIT_BITS;
  localparam int OFF_BITS   = PROD_BITS - UNIT_BITS + 1;

  localparam logic [UNIT_BITS-1:0] UNIT_MAX = {1'b0, {(UNIT_BITS-1){1'b1}}};

  typedef enum logic [2:0] {
    JOB_SINGLE = 3'b001,
    JOB_FIRST  = 3'b010,
    JOB_INNER  = 3'b100
  } pso_job_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic [WIDTH_BITS-1:0]        stroke_width;
    logic                         end_of_line;
  } pso_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left_x;
    logic signed [COORD_BITS-1:0] left_y;
    logic signed [COORD_BITS-1:0] right_x;
    logic signed [COORD_BITS-1:0] right_y;
    logic signed [COORD_BITS-1:0] border_z;
    logic                         dropped;
    logic                         line_done;
  } pso_out_t;

  typedef struct packed {
    pso_job_e                     kind;
    logic                         eol;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic [WIDTH_BITS-1:0]        pw;
    logic signed [COORD_BITS-1:0] hx;
    logic signed [COORD_BITS-1:0] hy;
    logic signed [COORD_BITS-1:0] hz;
    logic [WIDTH_BITS-1:0]        hw;
    logic signed [VEC_BITS-1:0]   dx;
    logic signed [VEC_BITS-1:0]   dy;
    logic signed [VEC_BITS-1:0]   dz;
  } pso_job_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [COORD_BITS:0] v);
    logic signed [COORD_BITS-1:0] r;
    if (v[COORD_BITS] != v[COORD_BITS-1]) begin
      r = v[COORD_BITS] ? {1'b1, {(COORD_BITS-1){1'b0}}} : {1'b0, {(COORD_BITS-1){1'b1}}};
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/pso_fifo.sv
`default_nettype none
module pso_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### rtl/pso_front.sv
`default_nettype none
module pso_front import pso_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    accept_i,
  input  wire pso_in_t item_i,
  output logic         job_push_o,
  output pso_job_t     job_o
);

  typedef enum logic [2:0] {
    SEEN_NONE  = 3'b001,
    SEEN_FIRST = 3'b010,
    SEEN_INNER = 3'b100
  } seen_e;

  seen_e                        seen_q, seen_d;
  logic signed [COORD_BITS-1:0] hx_q, hy_q, hz_q;
  logic [WIDTH_BITS-1:0]        hw_q;

  always_comb begin
    job_o.kind = JOB_SINGLE;
    job_o.eol  = item_i.end_of_line;
    job_o.px   = item_i.point_x;
    job_o.py   = item_i.point_y;
    job_o.pz   = item_i.point_z;
    job_o.pw   = item_i.stroke_width;
    job_o.hx   = hx_q;
    job_o.hy   = hy_q;
    job_o.hz   = hz_q;
    job_o.hw   = hw_q;
    job_o.dx   = VEC_BITS'(item_i.point_x) - VEC_BITS'(hx_q);
    job_o.dy   = VEC_BITS'(item_i.point_y) - VEC_BITS'(hy_q);
    job_o.dz   = VEC_BITS'(item_i.point_z) - VEC_BITS'(hz_q);
    job_push_o = 1'b0;
    seen_d     = seen_q;
    unique case (seen_q)
      SEEN_NONE: begin
        job_push_o = accept_i && item_i.end_of_line;
        if (accept_i && !item_i.end_of_line) begin
          seen_d = SEEN_FIRST;
        end
      end
      SEEN_FIRST: begin
        job_o.kind = JOB_FIRST;
        job_push_o = accept_i;
        if (accept_i) begin
          seen_d = item_i.end_of_line ? SEEN_NONE : SEEN_INNER;
        end
      end
      SEEN_INNER: begin
        job_o.kind = JOB_INNER;
        job_push_o = accept_i;
        if (accept_i && item_i.end_of_line) begin
          seen_d = SEEN_NONE;
        end
      end
      default: seen_d = SEEN_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= SEEN_NONE;
    end else begin
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hx_q <= item_i.point_x;
      hy_q <= item_i.point_y;
      hz_q <= item_i.point_z;
      hw_q <= item_i.stroke_width;
    end
  end

endmodule
`default_nettype wire

### rtl/pso_unit.sv
`default_nettype none
module pso_unit import pso_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic signed [VEC_BITS-1:0] vec_i [3],
  output logic                       done_o,
  output logic signed [UNIT_BITS-1:0] res_o [3]
);

  typedef enum logic [4:0] {
    U_IDLE = 5'b00001,
    U_SQ   = 5'b00010,
    U_ROOT = 5'b00100,
    U_LOAD = 5'b01000,
    U_DIV  = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  logic [MAG_BITS-1:0]         mag_q [3];
  logic [MAG_BITS-1:0]         mag_d [3];
  logic                        neg_q [3];
  logic                        neg_d [3];
  logic [SQ_BITS-1:0]          acc_q, acc_d, n_q, n_d, r_q, r_d;
  logic [4:0]                  cnt_q, cnt_d;
  logic [1:0]                  comp_q, comp_d;
  logic [LEN_BITS-1:0]         rem_q, rem_d;
  logic [UNIT_BITS-1:0]        dq_q, dq_d;
  logic signed [UNIT_BITS-1:0] res_q [3];
  logic signed [UNIT_BITS-1:0] res_d [3];
  logic                        done_q, done_d;

  logic [VEC_BITS-1:0]         abs_v [3];
  logic [VEC_BITS-1:0]         mx;
  logic [5:0]                  sh;
  logic [MAG_BITS-1:0]         msel;
  logic [2*MAG_BITS-1:0]       prod;
  logic [SQ_BITS-1:0]          sum_next, rbit, trial;
  logic [LEN_BITS-1:0]         len;
  logic [NUM_BITS-1:0]         num;
  logic [LEN_BITS:0]           dtry;
  logic [UNIT_BITS-1:0]        qv;

  assign done_o = done_q;
  assign res_o  = res_q;
  assign msel   = mag_q[comp_q];
  assign prod   = msel * msel;
  assign len    = r_q[LEN_BITS-1:0];

  always_comb begin
    mx = '0;
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vec_i[i][VEC_BITS-1] ? VEC_BITS'(-vec_i[i]) : VEC_BITS'(vec_i[i]);
      if (abs_v[i] > mx) begin
        mx = abs_v[i];
      end
    end
    sh = '0;
    for (int k = VEC_BITS; k >= 0; k--) begin
      if ((SQ_BITS'(mx) >> k) < SQ_BITS'(64'h8000_0000)) begin
        sh = 6'(k);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    n_d      = n_q;
    r_d      = r_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    rem_d    = rem_q;
    dq_d     = dq_q;
    res_d    = res_q;
    done_d   = 1'b0;
    sum_next = acc_q + SQ_BITS'(prod);
    rbit     = SQ_BITS'(1) << {cnt_q, 1'b0};
    trial    = r_q + rbit;
    num      = {msel, {(UNIT_BITS-1){1'b0}}} + NUM_BITS'(len >> 1);
    dtry     = {rem_q, dq_q[UNIT_BITS-1]};
    qv       = '0;
    unique case (state_q)
      U_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            neg_d[i] = vec_i[i][VEC_BITS-1];
            mag_d[i] = MAG_BITS'(SQ_BITS'(abs_v[i]) >> sh);
          end
          acc_d   = '0;
          comp_d  = '0;
          state_d = U_SQ;
        end
      end
      U_SQ: begin
        acc_d = sum_next;
        if (comp_q == 2'd2) begin
          n_d     = sum_next;
          r_d     = '0;
          cnt_d   = 5'(ROOT_STEPS - 1);
          state_d = U_ROOT;
        end else begin
          comp_d = comp_q + 1'b1;
        end
      end
      U_ROOT: begin
        if (n_q >= trial) begin
          n_d = n_q - trial;
          r_d = (r_q >> 1) + rbit;
        end else begin
          r_d = r_q >> 1;
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          comp_d = '0;
          if (acc_q == '0) begin
            for (int i = 0; i < 3; i++) begin
              res_d[i] = '0;
            end
            done_d  = 1'b1;
            state_d = U_IDLE;
          end else begin
            state_d = U_LOAD;
          end
        end
      end
      U_LOAD: begin
        rem_d   = LEN_BITS'(num >> UNIT_BITS);
        dq_d    = num[UNIT_BITS-1:0];
        cnt_d   = 5'(UNIT_BITS - 1);
        state_d = U_DIV;
      end
      U_DIV: begin
        if (dtry >= {1'b0, len}) begin
          rem_d = LEN_BITS'(dtry - {1'b0, len});
          dq_d  = {dq_q[UNIT_BITS-2:0], 1'b1};
        end else begin
          rem_d = dtry[LEN_BITS-1:0];
          dq_d  = {dq_q[UNIT_BITS-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          qv = (dq_d > UNIT_MAX) ? UNIT_MAX : dq_d;
          res_d[comp_q] = neg_q[comp_q] ? -$signed(qv) : $signed(qv);
          if (comp_q == 2'd2) begin
            done_d  = 1'b1;
            state_d = U_IDLE;
          end else begin
            comp_d  = comp_q + 1'b1;
            state_d = U_LOAD;
          end
        end
      end
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    n_q    <= n_d;
    r_q    <= r_d;
    cnt_q  <= cnt_d;
    comp_q <= comp_d;
    rem_q  <= rem_d;
    dq_q   <= dq_d;
    res_q  <= res_d;
  end

endmodule
`default_nettype wire

### rtl/pso_back.sv
`default_nettype none
module pso_back import pso_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_empty_i,
  input  wire pso_job_t               job_i,
  output logic                        job_pop_o,
  input  wire logic                   res_full_i,
  output logic                        res_push_o,
  output pso_out_t                    res_o,
  output logic                        unit_start_o,
  output logic signed [VEC_BITS-1:0]  unit_vec_o [3],
  input  wire logic                   unit_done_i,
  input  wire logic signed [UNIT_BITS-1:0] unit_res_i [3]
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_FWD  = 5'b00010,
    B_TAN  = 5'b00100,
    B_MUL  = 5'b01000,
    B_EMIT = 5'b10000
  } state_e;

  state_e                      state_q, state_d;
  pso_job_t                    job_q, job_d;
  logic signed [UNIT_BITS-1:0] fwd_q [3];
  logic signed [UNIT_BITS-1:0] fwd_d [3];
  logic signed [UNIT_BITS-1:0] bsu_q [3];
  logic signed [UNIT_BITS-1:0] bsu_d [3];
  logic signed [UNIT_BITS-1:0] tan_q [3];
  logic signed [UNIT_BITS-1:0] tan_d [3];
  logic                        cur_q, cur_d;
  logic [PROD_BITS-1:0]        px_q, py_q;
  logic                        negx_q, negy_q, drop_q;

  logic [WIDTH_BITS-1:0]        wsel;
  logic [UNIT_BITS-1:0]         atx, aty;
  logic signed [COORD_BITS-1:0] vx, vy, vz;
  logic [OFF_BITS-1:0]          ox_m, oy_m;
  logic signed [COORD_BITS:0]   ox, oy;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_vec_o[i] = VEC_BITS'(unit_res_i[i]) + VEC_BITS'(bsu_q[i]);
    end
    if (state_q == B_IDLE) begin
      unit_vec_o[0] = job_i.dx;
      unit_vec_o[1] = job_i.dy;
      unit_vec_o[2] = job_i.dz;
    end
  end

  assign wsel = cur_q ? job_q.pw : job_q.hw;
  assign atx  = tan_q[0][UNIT_BITS-1] ? UNIT_BITS'(-tan_q[0]) : UNIT_BITS'(tan_q[0]);
  assign aty  = tan_q[1][UNIT_BITS-1] ? UNIT_BITS'(-tan_q[1]) : UNIT_BITS'(tan_q[1]);
  assign vx   = cur_q ? job_q.px : job_q.hx;
  assign vy   = cur_q ? job_q.py : job_q.hy;
  assign vz   = cur_q ? job_q.pz : job_q.hz;

  always_comb begin
    ox_m = OFF_BITS'((px_q + PROD_BITS'(UNIT_MAX) + 1'b1) >> UNIT_BITS);
    oy_m = OFF_BITS'((py_q + PROD_BITS'(UNIT_MAX) + 1'b1) >> UNIT_BITS);
    ox   = negx_q ? -(COORD_BITS+1)'(ox_m) : (COORD_BITS+1)'(ox_m);
    oy   = negy_q ? -(COORD_BITS+1)'(oy_m) : (COORD_BITS+1)'(oy_m);
    if (drop_q) begin
      ox = '0;
      oy = '0;
    end
    res_o.left_x    = sat_coord((COORD_BITS+1)'(vx) - oy);
    res_o.left_y    = sat_coord((COORD_BITS+1)'(vy) + ox);
    res_o.right_x   = sat_coord((COORD_BITS+1)'(vx) + oy);
    res_o.right_y   = sat_coord((COORD_BITS+1)'(vy) - ox);
    res_o.border_z  = vz;
    res_o.dropped   = drop_q;
    res_o.line_done = cur_q;
  end

  assign res_push_o = (state_q == B_EMIT) && !res_full_i;

  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    fwd_d        = fwd_q;
    bsu_d        = bsu_q;
    tan_d        = tan_q;
    cur_d        = cur_q;
    job_pop_o    = 1'b0;
    unit_start_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          if (job_i.kind == JOB_SINGLE) begin
            for (int i = 0; i < 3; i++) begin
              tan_d[i] = '0;
            end
            cur_d   = 1'b1;
            state_d = B_MUL;
          end else begin
            unit_start_o = 1'b1;
            state_d      = B_FWD;
          end
        end
      end
      B_FWD: begin
        if (unit_done_i) begin
          fwd_d = unit_res_i;
          bsu_d = unit_res_i;
          cur_d = 1'b0;
          if (job_q.kind == JOB_INNER) begin
            unit_start_o = 1'b1;
            state_d      = B_TAN;
          end else begin
            tan_d   = unit_res_i;
            state_d = B_MUL;
          end
        end
      end
      B_TAN: begin
        if (unit_done_i) begin
          tan_d   = unit_res_i;
          state_d = B_MUL;
        end
      end
      B_MUL: state_d = B_EMIT;
      B_EMIT: begin
        if (!res_full_i) begin
          if (!cur_q && job_q.eol) begin
            cur_d   = 1'b1;
            tan_d   = fwd_q;
            state_d = B_MUL;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    fwd_q  <= fwd_d;
    bsu_q  <= bsu_d;
    tan_q  <= tan_d;
    cur_q  <= cur_d;
    px_q   <= wsel * atx;
    py_q   <= wsel * aty;
    negx_q <= tan_q[0][UNIT_BITS-1];
    negy_q <= tan_q[1][UNIT_BITS-1];
    drop_q <= (tan_q[0] == '0) && (tan_q[1] == '0) && (tan_q[2] == '0);
  end

endmodule
`default_nettype wire

### rtl/polyline_stroke_offset.sv
// A vertex's result is queued after the next vertex of its line arrives; a line's last
// vertex follows its neighbor's result, and a one-point line's result needs no unit vector.
// Vertices wait in a two-entry job queue, so a new vertex can be taken before the last is
// through; all unit vectors come from a single shared length unit (3 square steps,
// 32 root steps, then a division per component unless the vector is zero).
// Reset: asynchronous, active low; clears control state, queues empty, no vertex held.
`default_nettype none
module polyline_stroke_offset import pso_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push,
  output logic          full,
  input  wire pso_in_t  in_item_i,
  output logic          empty,
  input  wire logic     pop,
  output pso_out_t      out_item_o
);

  logic                        accept;
  logic                        job_push, job_full, job_pop, job_empty;
  pso_job_t                    job_in, job_out;
  logic                        res_push, res_full;
  pso_out_t                    res_in;
  logic                        unit_start, unit_done;
  logic signed [VEC_BITS-1:0]  unit_vec [3];
  logic signed [UNIT_BITS-1:0] unit_res [3];

  assign full   = job_full;
  assign accept = push && !job_full;

  pso_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (in_item_i),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  pso_fifo #(.T(pso_job_t), .DEPTH(2)) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  pso_unit u_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .vec_i   (unit_vec),
    .done_o  (unit_done),
    .res_o   (unit_res)
  );

  pso_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_empty_i  (job_empty),
    .job_i        (job_out),
    .job_pop_o    (job_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .unit_start_o (unit_start),
    .unit_vec_o   (unit_vec),
    .unit_done_i  (unit_done),
    .unit_res_i   (unit_res)
  );

  pso_fifo #(.T(pso_out_t), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef SYNTH
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result pushed into full queue");
  a_job_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full) else $error("job pushed into full queue");
  a_drop_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.dropped) |->
      (out_item_o.left_x == out_item_o.right_x && out_item_o.left_y == out_item_o.right_y))
    else $error("dropped item carries an offset");
`endif

endmodule
`default_nettype wire

### tb/polyline_stroke_offset_test.sv
`timescale 1ns / 100ps
`default_nettype none
module polyline_stroke_offset_test;
  import pso_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int UNIT_FRAC = UNIT_BITS - 1;

  typedef struct {
    pso_in_t  item;
    bit       has_fixed;
    pso_out_t fixed;
  } vertex_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     pop = 1'b0;
  logic     full;
  logic     empty;
  pso_in_t  in_item_i = '0;
  pso_out_t out_item_o;

  polyline_stroke_offset dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state
  longint    held_pt [3];
  longint    held_w;
  longint    back_unit [3];
  int        seen_cnt;
  pso_out_t  border_q [$];
  int        error_cnt = 0;
  bit        calm = 1'b0;

  task automatic report_mismatch(input string what);
    error_cnt++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic longint isqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  task automatic unit_vec(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned mx, s, len, q, lim;
    bit neg [3];
    mx = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (mag[i] > mx) mx = mag[i];
    end
    while ((mx >> 31) != 0) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
    if (s == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return;
    end
    len = isqrt(s);
    lim = (64'd1 << UNIT_FRAC) - 1;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << UNIT_FRAC) + (len >> 1)) / len;
      if (q > lim) q = lim;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (COORD_BITS - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi[COORD_BITS-1:0] : (v < lo ? lo[COORD_BITS-1:0] : v[COORD_BITS-1:0]);
  endfunction

  function automatic longint half_width_along(input longint w, input longint t);
    longint unsigned m, o;
    m = t < 0 ? -t : t;
    o = (longint'(w) * m + (64'd1 << UNIT_FRAC)) >> UNIT_BITS;
    return t < 0 ? -longint'(o) : longint'(o);
  endfunction

  function automatic pso_out_t make_border(input longint p [3], input longint w,
                                           input longint t [3], input bit done);
    pso_out_t r;
    bit drop;
    longint ox, oy;
    drop = t[0] == 0 && t[1] == 0 && t[2] == 0;
    ox = drop ? 0 : half_width_along(w, t[0]);
    oy = drop ? 0 : half_width_along(w, t[1]);
    r.left_x = clamp_coord(p[0] - oy);
    r.left_y = clamp_coord(p[1] + ox);
    r.right_x = clamp_coord(p[0] + oy);
    r.right_y = clamp_coord(p[1] - ox);
    r.border_z = p[2][COORD_BITS-1:0];
    r.dropped = drop;
    r.line_done = done;
    return r;
  endfunction

  task automatic predict_borders(input pso_in_t it);
    longint p [3], d [3], fwd [3], sum [3], t [3];
    longint w;
    p[0] = it.point_x;
    p[1] = it.point_y;
    p[2] = it.point_z;
    w = it.stroke_width;
    if (seen_cnt == 0) begin
      if (it.end_of_line) begin
        t = '{0, 0, 0};
        border_q = {border_q, make_border(p, w, t, 1'b1)};
        return;
      end
      held_pt = p;
      back_unit = '{0, 0, 0};
      held_w = w;
      seen_cnt = 1;
      return;
    end
    for (int i = 0; i < 3; i++) d[i] = p[i] - held_pt[i];
    unit_vec(d, fwd);
    if (seen_cnt == 1) begin
      border_q = {border_q, make_border(held_pt, held_w, fwd, 1'b0)};
    end else begin
      for (int i = 0; i < 3; i++) sum[i] = fwd[i] + back_unit[i];
      unit_vec(sum, t);
      border_q = {border_q, make_border(held_pt, held_w, t, 1'b0)};
    end
    if (it.end_of_line) begin
      border_q = {border_q, make_border(p, w, fwd, 1'b1)};
      seen_cnt = 0;
      held_pt = '{0, 0, 0};
      back_unit = '{0, 0, 0};
      held_w = 0;
      return;
    end
    held_pt = p;
    back_unit = fwd;
    held_w = w;
    seen_cnt = 2;
  endtask

  function automatic pso_in_t vtx(input int x, input int y, input int z,
                                  input int w, input bit eol);
    pso_in_t r;
    r.point_x = x[COORD_BITS-1:0];
    r.point_y = y[COORD_BITS-1:0];
    r.point_z = z[COORD_BITS-1:0];
    r.stroke_width = w[WIDTH_BITS-1:0];
    r.end_of_line = eol;
    return r;
  endfunction

  function automatic int rand_coord(input int span);
    if (span == 0) return $urandom;
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic send_vertex(input pso_in_t it);
    while (!calm && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_borders(it);
  endtask

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (border_q.size() == 0) begin
          report_mismatch("unexpected border item");
        end else begin
          pso_out_t e;
          e = border_q.pop_front();
          if (out_item_o.left_x !== e.left_x) report_mismatch("left_x");
          if (out_item_o.left_y !== e.left_y) report_mismatch("left_y");
          if (out_item_o.right_x !== e.right_x) report_mismatch("right_x");
          if (out_item_o.right_y !== e.right_y) report_mismatch("right_y");
          if (out_item_o.border_z !== e.border_z) report_mismatch("border_z");
          if (out_item_o.dropped !== e.dropped) report_mismatch("dropped");
          if (out_item_o.line_done !== e.line_done) report_mismatch("line_done");
        end
      end
      pop <= calm || ($urandom_range(99) >= 13);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    vertex_row_t rows [$];
    vertex_row_t row;
    pso_in_t it;
    int max_c, min_c, n_pts, span, idle_cnt;
    held_pt = '{0, 0, 0};
    back_unit = '{0, 0, 0};
    held_w = 0;
    seen_cnt = 0;
    max_c = (1 << (COORD_BITS - 1)) - 1;
    min_c = -(1 << (COORD_BITS - 1));

    // one-point lines: dropped, vertex passes through
    row.item = vtx(max_c, min_c, max_c, 16'hffff, 1'b1);
    row.has_fixed = 1'b1;
    row.fixed = '{left_x: max_c[COORD_BITS-1:0], left_y: min_c[COORD_BITS-1:0],
                  right_x: max_c[COORD_BITS-1:0], right_y: min_c[COORD_BITS-1:0],
                  border_z: max_c[COORD_BITS-1:0], dropped: 1'b1, line_done: 1'b1};
    rows = {rows, row};
    row.item = vtx(min_c, max_c, min_c, 0, 1'b1);
    row.fixed = '{left_x: min_c[COORD_BITS-1:0], left_y: max_c[COORD_BITS-1:0],
                  right_x: min_c[COORD_BITS-1:0], right_y: max_c[COORD_BITS-1:0],
                  border_z: min_c[COORD_BITS-1:0], dropped: 1'b1, line_done: 1'b1};
    rows = {rows, row};
    row.has_fixed = 1'b0;
    // extremes, saturation
    row.item = vtx(max_c, max_c, 0, 16'hffff, 1'b0); rows = {rows, row};
    row.item = vtx(min_c, min_c, 0, 16'hffff, 1'b0); rows = {rows, row};
    row.item = vtx(max_c, min_c, max_c, 16'hffff, 1'b1); rows = {rows, row};
    // zero-length segments and a pure vertical line
    row.item = vtx(256, 256, 0, 512, 1'b0); rows = {rows, row};
    row.item = vtx(256, 256, 0, 512, 1'b0); rows = {rows, row};
    row.item = vtx(1280, 256, 0, 512, 1'b0); rows = {rows, row};
    row.item = vtx(1280, 256, 5000, 512, 1'b0); rows = {rows, row};
    row.item = vtx(1280, 256, 5000, 512, 1'b1); rows = {rows, row};
    // opposite segments
    row.item = vtx(0, 0, 0, 1024, 1'b0); rows = {rows, row};
    row.item = vtx(1000, 0, 0, 1024, 1'b0); rows = {rows, row};
    row.item = vtx(0, 0, 0, 1024, 1'b1); rows = {rows, row};
    // ordinary bend
    row.item = vtx(-300, 40, 7, 300, 1'b0); rows = {rows, row};
    row.item = vtx(100, 500, -9, 1, 1'b0); rows = {rows, row};
    row.item = vtx(900, 450, 30, 65000, 1'b0); rows = {rows, row};
    row.item = vtx(1200, -800, 0, 777, 1'b1); rows = {rows, row};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].has_fixed) begin
        send_vertex(rows[i].item);
        border_q[border_q.size() - 1] = rows[i].fixed;
      end else begin
        send_vertex(rows[i].item);
      end
    end

    idle_cnt = 0;
    while (idle_cnt < 940) begin
      calm = (idle_cnt >= 300 && idle_cnt < 420);
      n_pts = $urandom_range(99) < 8 ? 1 : $urandom_range(2, 7);
      case ($urandom_range(3))
        0: span = 0;
        1: span = 4096;
        2: span = 8;
        default: span = 1 << 20;
      endcase
      for (int k = 0; k < n_pts; k++) begin
        if ($urandom_range(9) == 0 && k > 0) begin
          it = vtx(int'(it.point_x), int'(it.point_y), int'(it.point_z), $urandom,
                   k == n_pts - 1);
        end else begin
          it = vtx(rand_coord(span), rand_coord(span), rand_coord(span),
                   $urandom, k == n_pts - 1);
        end
        send_vertex(it);
        idle_cnt++;
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (border_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### polyline_stroke_offset.f
rtl/pso_pkg.sv
rtl/pso_fifo.sv
rtl/pso_front.sv
rtl/pso_unit.sv
rtl/pso_back.sv
rtl/polyline_stroke_offset.sv
tb/polyline_stroke_offset_test.sv
